FILE: design/dsk_pkg.sv
// ----------------------------------------------------------------------------
// dsk_pkg: shared types and constants for the decimal sort-key unit
// Field widths, character codes, key constants and the handoff struct
// between the accumulator and the key encoder.
// ----------------------------------------------------------------------------
package dsk_pkg;

   parameter int DSK_MAX_CHARS = 64;

   localparam int CHAR_W     = 8;
   localparam int EXP_W      = 18;          // holds +-99999
   localparam int EXP_WIDE_W = EXP_W + 4;   // headroom for x10 plus digit
   localparam int MANT_W     = 37;          // holds 11 decimal digits
   localparam int EB_W       = 11;          // biased exponent 2..2000
   localparam int KEY_W      = 52;

   localparam int EXP_SAT  = 99999;
   localparam int EXP_HIGH = 1000;
   localparam int EXP_LOW  = -998;
   localparam int EXP_BIAS = 1000;

   localparam logic [MANT_W-1:0] MANT_MAX         = 37'd99999999999;
   localparam logic [MANT_W-1:0] MANT_CARRY       = 37'd10000000000;
   localparam logic [MANT_W-1:0] MANT_ROUND_LIMIT = 37'd10000000000;

   localparam logic [KEY_W-1:0] KEY_SIGN_UNIT = 52'd1000000000000000;
   localparam logic [KEY_W-1:0] KEY_EXP_UNIT  = 52'd100000000000;
   localparam logic [KEY_W-1:0] KEY_OFFSET    = 52'd2200099999999999;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // finished number, handed from accumulator to key encoder
   typedef struct packed {
      logic              neg;
      logic [EB_W-1:0]   exp_biased;
      logic [MANT_W-1:0] mant;
   } final_type;

   // non-digits count as zero
   function automatic logic [3:0] digit_of(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return 4'(c - CHAR_ZERO);
      end
      return 4'd0;
   endfunction

   function automatic logic signed [EXP_W-1:0] sat_exp(
      input logic signed [EXP_WIDE_W-1:0] v);
      if (v > EXP_WIDE_W'(EXP_SAT)) begin
         return EXP_W'(EXP_SAT);
      end
      if (v < EXP_WIDE_W'(-EXP_SAT)) begin
         return EXP_W'(-EXP_SAT);
      end
      return EXP_W'(v);
   endfunction

endpackage

FILE: design/decimal_sci_to_sort_key_unit.sv
// ----------------------------------------------------------------------------
// decimal_sci_to_sort_key_unit: decimal scientific text to 52-bit sort key
// Streams exponent then mantissa characters and emits one order-preserving
// key per number on the last mantissa character.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_ready  | req_char_code, req_mode, req_last
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_sort_key
//
// One character request per cycle, sustained while nothing stalls. The last
// mantissa character of a number is taken into the input register, the
// character update is then loaded into the final register, and the encoded
// key into the response register, from which it appears on rsp. The
// per-character update (x10 on the exponent and mantissa, rounding, exponent
// adjust and clamp) is one pass of logic.
// Reset is synchronous and puts the unit in its idle, empty state; req_ready
// is high in the first cycle after reset.
// A stalled rsp backs up through the final register; characters that end no
// number keep flowing until the input register holds a last mantissa
// character that has nowhere to go.
//
// Exponent and mantissa parts each take an optional leading sign. The
// mantissa keeps 11 significant digits, rounding half up on the twelfth; a
// round-up carry gives 10000000000 and bumps the exponent. Characters past
// MAX_CHARS in one part are dropped.
// ----------------------------------------------------------------------------
module decimal_sci_to_sort_key_unit #(
   parameter int MAX_CHARS = dsk_pkg::DSK_MAX_CHARS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [dsk_pkg::CHAR_W-1:0] req_char_code,
   input  logic                       req_mode,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dsk_pkg::KEY_W-1:0]  rsp_sort_key
);
   import dsk_pkg::*;

   // finished number between accumulator and encoder
   logic      num_valid;
   logic      num_ready;
   final_type num_final;

   dsk_accum #(
      .MAX_CHARS (MAX_CHARS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_char_code (req_char_code),
      .in_mode      (req_mode),
      .in_last      (req_last),
      .out_valid    (num_valid),
      .out_ready    (num_ready),
      .out_final    (num_final)
   );

   dsk_key u_key (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_final  (num_final),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_key   (rsp_sort_key)
   );

endmodule

FILE: design/dsk_accum.sv
// ----------------------------------------------------------------------------
// dsk_accum: character accumulator
// Input register, per-character update of exponent and mantissa state, and
// a final register that holds the adjusted, clamped number of each finished number.
// ----------------------------------------------------------------------------
module dsk_accum #(
   parameter int MAX_CHARS = dsk_pkg::DSK_MAX_CHARS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dsk_pkg::CHAR_W-1:0]  in_char_code,
   input  logic                        in_mode,
   input  logic                        in_last,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dsk_pkg::final_type          out_final
);
   import dsk_pkg::*;

   localparam int POS_W = $clog2(MAX_CHARS + 1);
   localparam int ADJ_W = POS_W + 2;
   localparam int E_W   = ((EXP_W > ADJ_W) ? EXP_W : ADJ_W) + 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);

   // input register
   logic              in_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              mode_ff;
   logic              last_ff;

   // number state
   logic signed [EXP_W-1:0] exp_ff,       exp_in;
   logic                    exp_neg_ff,   exp_neg_in;
   logic [MANT_W-1:0]       mant_ff,      mant_in;
   logic                    mant_neg_ff,  mant_neg_in;
   logic [POS_W-1:0]        pos_ff,       pos_in;
   logic [POS_W-1:0]        point_ff,     point_in;
   logic                    point_vld_ff, point_vld_in;
   logic [POS_W-1:0]        nz_ff,        nz_in;
   logic                    seen_nz_ff,   seen_nz_in;
   logic                    rnd_done_ff,  rnd_done_in;
   logic                    start_ff,     start_in;

   // output register
   logic      out_valid_ff;
   final_type final_ff, final_in;

   // state after this character, before any end-of-part clear
   logic signed [EXP_W-1:0] exp_upd;
   logic                    exp_neg_upd;
   logic [MANT_W-1:0]       mant_upd;
   logic                    mant_neg_upd;
   logic [POS_W-1:0]        pos_upd;
   logic [POS_W-1:0]        point_upd;
   logic                    point_vld_upd;
   logic [POS_W-1:0]        nz_upd;
   logic                    seen_nz_upd;
   logic                    rnd_done_upd;

   logic                         active, is_sign, is_point, is_neg_sign;
   logic [3:0]                   dig;
   logic signed [EXP_WIDE_W-1:0] exp_wide, exp_times, dig_wide, dig_signed;
   logic signed [EXP_W-1:0]      exp_dig, exp_inc;
   logic [MANT_W-1:0]            mant_times, mant_round;
   logic                         mant_over, round_up, mant_carry;

   logic [POS_W-1:0]        pt_eff, nz_eff;
   logic signed [ADJ_W-1:0] adj;
   logic signed [E_W-1:0]   e_full, e_clamp, e_biased;

   logic emit, consume, out_en;

   assign emit    = mode_ff && last_ff;
   assign out_en  = !out_valid_ff || out_ready;
   assign consume = in_valid_ff && (!emit || out_en);
   assign in_ready = !in_valid_ff || consume;

   // character decode and arithmetic candidates
   always_comb begin
      active      = pos_ff < POS_LIMIT;
      is_sign     = start_ff && (char_ff == CHAR_PLUS || char_ff == CHAR_MINUS);
      is_neg_sign = char_ff == CHAR_MINUS;
      is_point    = char_ff == CHAR_POINT;
      dig         = digit_of(char_ff);

      exp_wide   = EXP_WIDE_W'(exp_ff);
      exp_times  = (exp_wide <<< 3) + (exp_wide <<< 1);
      dig_wide   = $signed(EXP_WIDE_W'(dig));
      dig_signed = exp_neg_ff ? -dig_wide : dig_wide;
      exp_dig    = sat_exp(exp_times + dig_signed);
      exp_inc    = sat_exp(exp_wide + EXP_WIDE_W'(1));

      // x10 only used while below 10^10, so it cannot overflow
      mant_times = (mant_ff << 3) + (mant_ff << 1) + MANT_W'(dig);
      mant_over  = mant_ff >= MANT_ROUND_LIMIT;
      round_up   = dig >= 4'd5;
      mant_round = mant_ff + MANT_W'(round_up);
      mant_carry = (mant_ff == MANT_MAX) && round_up;
   end

   // per-character update
   always_comb begin
      exp_upd       = exp_ff;
      exp_neg_upd   = exp_neg_ff;
      mant_upd      = mant_ff;
      mant_neg_upd  = mant_neg_ff;
      pos_upd       = pos_ff;
      point_upd     = point_ff;
      point_vld_upd = point_vld_ff;
      nz_upd        = nz_ff;
      seen_nz_upd   = seen_nz_ff;
      rnd_done_upd  = rnd_done_ff;
      if (active) begin
         pos_upd = pos_ff + POS_W'(1);
         if (!mode_ff) begin
            if (is_sign) begin
               exp_neg_upd = is_neg_sign;
            end else begin
               exp_upd = exp_dig;
            end
         end else if (is_sign) begin
            mant_neg_upd = is_neg_sign;
         end else begin
            if (is_point) begin
               point_upd     = pos_ff;
               point_vld_upd = 1'b1;
            end else if (!seen_nz_ff && dig != 4'd0) begin
               nz_upd      = pos_ff;
               seen_nz_upd = 1'b1;
            end
            if (!rnd_done_ff && !is_point) begin
               if (mant_over) begin
                  rnd_done_upd = 1'b1;
                  if (mant_carry) begin
                     mant_upd = MANT_CARRY;
                     exp_upd  = exp_inc;
                  end else begin
                     mant_upd = mant_round;
                  end
               end else begin
                  mant_upd = mant_times;
               end
            end
         end
      end
   end

   // exponent adjust, zero force and clamp for the finished number
   always_comb begin
      pt_eff = point_vld_upd ? point_upd : pos_upd;
      nz_eff = seen_nz_upd ? nz_upd : pos_upd;
      adj    = $signed({2'b00, pt_eff}) - $signed({2'b00, nz_eff})
               + $signed({{(ADJ_W-1){1'b0}}, (nz_eff > pt_eff)});
      e_full = E_W'(exp_upd) + E_W'(adj);
      if (mant_upd == '0) begin
         e_clamp = '0;
      end else if (e_full > E_W'(EXP_HIGH)) begin
         e_clamp = E_W'(EXP_HIGH);
      end else if (e_full < E_W'(EXP_LOW)) begin
         e_clamp = E_W'(EXP_LOW);
      end else begin
         e_clamp = e_full;
      end
      e_biased            = e_clamp + E_W'(EXP_BIAS);
      final_in.neg        = mant_neg_upd;
      final_in.exp_biased = e_biased[EB_W-1:0];
      final_in.mant       = mant_upd;
   end

   // end of part: exponent part keeps the exponent, mantissa part clears all
   always_comb begin
      exp_in       = exp_upd;
      exp_neg_in   = exp_neg_upd;
      mant_in      = mant_upd;
      mant_neg_in  = mant_neg_upd;
      pos_in       = pos_upd;
      point_in     = point_upd;
      point_vld_in = point_vld_upd;
      nz_in        = nz_upd;
      seen_nz_in   = seen_nz_upd;
      rnd_done_in  = rnd_done_upd;
      start_in     = start_ff && !active;
      if (last_ff) begin
         mant_in      = '0;
         mant_neg_in  = 1'b0;
         pos_in       = '0;
         point_in     = '0;
         point_vld_in = 1'b0;
         nz_in        = '0;
         seen_nz_in   = 1'b0;
         rnd_done_in  = 1'b0;
         start_in     = 1'b1;
         if (mode_ff) begin
            exp_in     = '0;
            exp_neg_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         exp_ff       <= '0;
         exp_neg_ff   <= 1'b0;
         mant_ff      <= '0;
         mant_neg_ff  <= 1'b0;
         pos_ff       <= '0;
         point_ff     <= '0;
         point_vld_ff <= 1'b0;
         nz_ff        <= '0;
         seen_nz_ff   <= 1'b0;
         rnd_done_ff  <= 1'b0;
         start_ff     <= 1'b1;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (out_en) begin
            out_valid_ff <= consume && emit;
         end
         if (consume) begin
            exp_ff       <= exp_in;
            exp_neg_ff   <= exp_neg_in;
            mant_ff      <= mant_in;
            mant_neg_ff  <= mant_neg_in;
            pos_ff       <= pos_in;
            point_ff     <= point_in;
            point_vld_ff <= point_vld_in;
            nz_ff        <= nz_in;
            seen_nz_ff   <= seen_nz_in;
            rnd_done_ff  <= rnd_done_in;
            start_ff     <= start_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (in_ready) begin
         char_ff <= in_char_code;
         mode_ff <= in_mode;
         last_ff <= in_last;
      end
      if (consume && emit) begin
         final_ff <= final_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_final = final_ff;

endmodule

FILE: design/dsk_key.sv
// ----------------------------------------------------------------------------
// dsk_key: sort key encoder
// Packs sign, biased exponent and mantissa into the order-preserving key and
// holds it in the response register.
// ----------------------------------------------------------------------------
module dsk_key (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  dsk_pkg::final_type         in_final,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [dsk_pkg::KEY_W-1:0]  out_key
);
   import dsk_pkg::*;

   logic             out_valid_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] sign_part, exp_part, body;

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      sign_part = in_final.neg ? KEY_SIGN_UNIT : (KEY_SIGN_UNIT << 1);
      exp_part  = KEY_W'(in_final.exp_biased) * KEY_EXP_UNIT;
      body      = sign_part + exp_part + KEY_W'(in_final.mant);
      key_in    = in_final.neg ? (KEY_OFFSET - body) : (body + KEY_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         key_ff <= key_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_key   = key_ff;

endmodule

FILE: design/dsk_checker.sv
// ----------------------------------------------------------------------------
// dsk_checker: port-level checks for the sort-key unit
// Reset behavior, response hold under stall, and backpressure ordering.
// ----------------------------------------------------------------------------
module dsk_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [dsk_pkg::CHAR_W-1:0] req_char_code,
   input logic                       req_mode,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dsk_pkg::KEY_W-1:0]  rsp_sort_key
);
   import dsk_pkg::*;

   // no response straight out of reset
   a_rsp_empty_after_reset: assert property (
      @(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // empty pipeline takes a request right after reset
   a_req_ready_after_reset: assert property (
      @(posedge clock) disable iff (reset) $past(reset) |-> req_ready)
      else $error("req_ready low right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sort_key))
      else $error("stalled response changed or dropped");

   // input only backs up when the output is blocked
   a_backpressure_source: assert property (
      @(posedge clock) disable iff (reset) !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low while response side is free");

endmodule

bind decimal_sci_to_sort_key_unit dsk_checker u_dsk_checker (.*);
